// ===== rtl/core/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric sensor compensation package
// Shared widths, register indexes, calibration fields and the coefficient
// bundle that passes from the coefficient stages to the evaluation stages.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

   // Port widths.
   localparam int unsigned RAW_W  = 24;
   localparam int unsigned TEMP_W = 16;
   localparam int unsigned PRES_W = 23;
   localparam int unsigned CSR_W  = 48;

   // Internal widths of the fixed-point datapath.
   localparam int unsigned TX_W = 60;   // temperature times 2^48
   localparam int unsigned TQ_W = 28;   // temperature in 1/65536 degC
   localparam int unsigned TC_W = 20;   // rounded temperature before clamping
   localparam int unsigned A3_W = 33;
   localparam int unsigned A2_W = 54;
   localparam int unsigned A1_W = 83;
   localparam int unsigned A0_W = 108;
   localparam int unsigned H2_W = 62;
   localparam int unsigned H1_W = 90;
   localparam int unsigned N_W  = 120;  // pressure times 2^85
   localparam int unsigned PW_W = 41;   // rounded pressure before clamping

   // Stages from the accept edge to the result registers.
   localparam int unsigned PIPE_DEPTH = 10;

   // Output limits.
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
   localparam logic [PRES_W-1:0]        PRES_MAX = 23'h7F_FFFF;

   // Rounding offsets.
   localparam logic signed [TX_W-1:0] TQ_HALF   = 60'sh000_0000_8000_0000;
   localparam logic signed [TX_W-1:0] TC_HALF   = 60'sh000_0080_0000_0000;
   localparam logic signed [N_W-1:0]  PRES_HALF = 120'sh1 <<< 78;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_TEMP_CALIB   = 2'd0,
      CSR_PRES_CALIB_A = 2'd1,
      CSR_PRES_CALIB_B = 2'd2,
      CSR_PRES_CALIB_C = 2'd3
   } csr_index_type;

   // Calibration words unpacked from the register bytes.
   typedef struct packed {
      logic        [15:0] t1;
      logic        [15:0] t2;
      logic signed [7:0]  t3;
      logic signed [15:0] p1;
      logic signed [15:0] p2;
      logic signed [7:0]  p3;
      logic signed [7:0]  p4;
      logic        [15:0] p5;
      logic        [15:0] p6;
      logic signed [7:0]  p7;
      logic signed [7:0]  p8;
      logic signed [15:0] p9;
      logic signed [7:0]  p10;
      logic signed [7:0]  p11;
   } calib_type;

   // Pressure polynomial grouped by powers of temperature:
   // N = a0 + tq * (a1 + tq * (a2 + tq * a3)).
   typedef struct packed {
      logic signed [A0_W-1:0] a0;
      logic signed [A1_W-1:0] a1;
      logic signed [A2_W-1:0] a2;
      logic signed [A3_W-1:0] a3;
   } coef_type;

endpackage

`default_nettype wire

// ===== rtl/core/bsc_temp.sv =====
// ----------------------------------------------------------------------------
// Temperature stages
// Three register stages: products of the raw count, the exact quadratic, then
// the two roundings with the clamp of the reported temperature.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_temp (
   input  wire logic                                 clock,
   input  wire logic [bsc_pkg::RAW_W-1:0]            temp_count,
   input  wire bsc_pkg::calib_type                   calib,
   output logic signed [bsc_pkg::TQ_W-1:0]           tq,
   output logic signed [bsc_pkg::TEMP_W-1:0]         temp_comp,
   output logic                                      temp_sat
);

   logic signed [24:0]               d;
   logic signed [41:0]               dt2_in, dt2_ff;
   logic signed [49:0]               dd_in, dd_ff;
   logic signed [57:0]               ddt3;
   logic signed [bsc_pkg::TX_W-1:0]  tx_in, tx_ff;
   logic signed [bsc_pkg::TX_W-1:0]  tq_round, tc_round;
   logic signed [bsc_pkg::TC_W-1:0]  tc_wide;
   logic signed [bsc_pkg::TQ_W-1:0]  tq_in, tq_ff;
   logic signed [bsc_pkg::TEMP_W-1:0] tc_in, tc_ff;
   logic                             sat_in, sat_ff;

   // Stage 1: offset count and its products.
   assign d      = $signed({1'b0, temp_count}) - $signed({1'b0, calib.t1, 8'h00});
   assign dt2_in = d * $signed({1'b0, calib.t2});
   assign dd_in  = d * d;

   // Stage 2: temperature times 2^48.
   assign ddt3  = dd_ff * $signed(calib.t3);
   assign tx_in = $signed({dt2_ff, 18'd0}) + ddt3;

   // Stage 3: fine temperature for the pressure path and the clamped output.
   assign tq_round = tx_ff + bsc_pkg::TQ_HALF;
   assign tc_round = tx_ff + bsc_pkg::TC_HALF;
   assign tq_in    = tq_round[bsc_pkg::TX_W-1:32];
   assign tc_wide  = tc_round[bsc_pkg::TX_W-1:40];

   always_comb begin
      priority if (tc_wide > $signed(bsc_pkg::TC_W'(bsc_pkg::TEMP_MAX))) begin
         tc_in  = bsc_pkg::TEMP_MAX;
         sat_in = 1'b1;
      end else if (tc_wide < bsc_pkg::TC_W'(bsc_pkg::TEMP_MIN)) begin
         tc_in  = bsc_pkg::TEMP_MIN;
         sat_in = 1'b1;
      end else begin
         tc_in  = tc_wide[bsc_pkg::TEMP_W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      dt2_ff <= dt2_in;
      dd_ff  <= dd_in;
      tx_ff  <= tx_in;
      tq_ff  <= tq_in;
      tc_ff  <= tc_in;
      sat_ff <= sat_in;
   end

   assign tq        = tq_ff;
   assign temp_comp = tc_ff;
   assign temp_sat  = sat_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bsc_coef.sv =====
// ----------------------------------------------------------------------------
// Pressure coefficient stages
// Three register stages that form the temperature-free parts of the pressure
// polynomial from the raw pressure count and its square and cube.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_coef (
   input  wire logic                      clock,
   input  wire logic [bsc_pkg::RAW_W-1:0] press_count,
   input  wire bsc_pkg::calib_type        calib,
   output bsc_pkg::coef_type              coef
);

   logic [bsc_pkg::RAW_W-1:0]          up_ff;
   logic [47:0]                        u2_in, u2_ff;
   logic [71:0]                        u3_in, u3_ff;
   logic signed [16:0]                 p1_adj, p2_adj;
   logic signed [32:0]                 m4_in, m4_ff, m3_in, m3_ff;
   logic signed [41:0]                 mp1_in, mp1_ff, mp2_in, mp2_ff;
   logic signed [64:0]                 m9;
   logic signed [56:0]                 m10;
   logic signed [80:0]                 m11;
   logic signed [bsc_pkg::A3_W-1:0]    a3_in, a3_ff;
   logic signed [bsc_pkg::A2_W-1:0]    a2_in, a2_ff;
   logic signed [bsc_pkg::A1_W-1:0]    a1_in, a1_ff;
   logic signed [bsc_pkg::A0_W-1:0]    a0p_in, a0p_ff, a0_in;
   bsc_pkg::coef_type                  coef_ff;

   // Stage 1: square of the count and the single products with it.
   assign p1_adj = $signed({calib.p1[15], calib.p1}) - 17'sd16384;
   assign p2_adj = $signed({calib.p2[15], calib.p2}) - 17'sd16384;
   assign u2_in  = press_count * press_count;
   assign m4_in  = calib.p4 * $signed({1'b0, press_count});
   assign m3_in  = calib.p3 * $signed({1'b0, press_count});
   assign mp1_in = p1_adj * $signed({1'b0, press_count});
   assign mp2_in = p2_adj * $signed({1'b0, press_count});

   // Stage 2: cube of the count and most of the grouped sums.
   assign u3_in  = u2_ff * up_ff;
   assign m9     = calib.p9 * $signed({1'b0, u2_ff});
   assign m10    = calib.p10 * $signed({1'b0, u2_ff});
   assign a3_in  = $signed({calib.p8, 22'd0}) + m4_ff;
   assign a2_in  = $signed({calib.p7, 45'd0}) + $signed({m3_ff, 21'd0});
   assign a1_in  = $signed({1'b0, calib.p6, 63'd0}) + $signed({mp2_ff, 40'd0})
                 + $signed({m10, 21'd0});
   assign a0p_in = $signed({1'b0, calib.p5, 88'd0}) + $signed({mp1_ff, 65'd0})
                 + $signed({m9, 37'd0});

   // Stage 3: cubic term closes the constant group.
   assign m11   = calib.p11 * $signed({1'b0, u3_ff});
   assign a0_in = a0p_ff + $signed({m11, 20'd0});

   always_ff @(posedge clock) begin
      up_ff      <= press_count;
      u2_ff      <= u2_in;
      m4_ff      <= m4_in;
      m3_ff      <= m3_in;
      mp1_ff     <= mp1_in;
      mp2_ff     <= mp2_in;
      u3_ff      <= u3_in;
      a3_ff      <= a3_in;
      a2_ff      <= a2_in;
      a1_ff      <= a1_in;
      a0p_ff     <= a0p_in;
      coef_ff.a0 <= a0_in;
      coef_ff.a1 <= a1_ff;
      coef_ff.a2 <= a2_ff;
      coef_ff.a3 <= a3_ff;
   end

   assign coef = coef_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bsc_horner.sv =====
// ----------------------------------------------------------------------------
// Pressure evaluation stages
// Six register stages that evaluate the grouped polynomial in the fine
// temperature by Horner's rule, with wide products cut into slices of up to 31 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_horner (
   input  wire logic                              clock,
   input  wire logic signed [bsc_pkg::TQ_W-1:0]   tq,
   input  wire bsc_pkg::coef_type                 coef,
   output logic signed [bsc_pkg::N_W-1:0]         pres_scaled
);

   logic signed [bsc_pkg::TQ_W-1:0] tq4_ff, tq5_ff, tq6_ff;
   logic signed [bsc_pkg::H2_W-1:0] h2_in, h2_ff;
   logic signed [bsc_pkg::H1_W-1:0] h1_in, h1_ff;
   logic signed [59:0]              p2l_in, p2l_ff, pl_in, pl_ff, pm_in, pm_ff;
   logic signed [58:0]              p2h_in, p2h_ff;
   logic signed [55:0]              ph_in, ph_ff;
   logic signed [bsc_pkg::N_W-1:0]  q_in, q_ff, n_in, n_ff;
   logic signed [bsc_pkg::A1_W-1:0] a1_4_ff, a1_5_ff;
   logic signed [bsc_pkg::A0_W-1:0] a0_4_ff, a0_5_ff, a0_6_ff, a0_7_ff, a0_8_ff;

   // Stage 4: innermost Horner step.
   assign h2_in = coef.a2 + tq * coef.a3;

   // Stage 5: two slices of the next product.
   assign p2l_in = tq4_ff * $signed({1'b0, h2_ff[30:0]});
   assign p2h_in = tq4_ff * $signed(h2_ff[61:31]);

   // Stage 6: merge the slices with the linear group.
   assign h1_in = a1_5_ff + $signed({p2h_ff, 31'd0}) + p2l_ff;

   // Stage 7: three slices of the outer product.
   assign pl_in = tq6_ff * $signed({1'b0, h1_ff[30:0]});
   assign pm_in = tq6_ff * $signed({1'b0, h1_ff[61:31]});
   assign ph_in = tq6_ff * $signed(h1_ff[89:62]);

   // Stage 8: merge the slices.
   assign q_in = $signed({ph_ff, 62'd0}) + $signed({pm_ff, 31'd0}) + pl_ff;

   // Stage 9: add the constant group and the rounding offset.
   assign n_in = a0_8_ff + q_ff + bsc_pkg::PRES_HALF;

   always_ff @(posedge clock) begin
      tq4_ff  <= tq;
      tq5_ff  <= tq4_ff;
      tq6_ff  <= tq5_ff;
      a1_4_ff <= coef.a1;
      a1_5_ff <= a1_4_ff;
      a0_4_ff <= coef.a0;
      a0_5_ff <= a0_4_ff;
      a0_6_ff <= a0_5_ff;
      a0_7_ff <= a0_6_ff;
      a0_8_ff <= a0_7_ff;
      h2_ff   <= h2_in;
      p2l_ff  <= p2l_in;
      p2h_ff  <= p2h_in;
      h1_ff   <= h1_in;
      pl_ff   <= pl_in;
      pm_ff   <= pm_in;
      ph_ff   <= ph_in;
      q_ff    <= q_in;
      n_ff    <= n_in;
   end

   assign pres_scaled = n_ff;

endmodule

`default_nettype wire

// ===== rtl/core/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Turns one raw pressure and temperature pair into compensated temperature
// (1/256 degC) and pressure (1/64 Pa) with a saturation flag.
//
//   Channel  Ports                                  Handshake
//   input    req_press_count, req_temp_count        start, busy (never high)
//   result   rsp_temp_comp, rsp_pres_comp,          rsp_valid, one cycle
//            rsp_saturated
//   config   csr_index, csr_wdata                   csr_write_enable
//
// An item is taken in every cycle that start is high. Its result is formed by
// the ten register stages of the multiplier pipeline.
// Reset clears the calibration registers and the stage valid bits.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [bsc_pkg::RAW_W-1:0]          req_press_count,
   input  wire logic [bsc_pkg::RAW_W-1:0]          req_temp_count,
   output logic                                    rsp_valid,
   output logic signed [bsc_pkg::TEMP_W-1:0]       rsp_temp_comp,
   output logic [bsc_pkg::PRES_W-1:0]              rsp_pres_comp,
   output logic                                    rsp_saturated,
   input  wire logic                               csr_write_enable,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [bsc_pkg::CSR_W-1:0]          csr_wdata
);

   logic [39:0]                         temp_calib_ff;
   logic [47:0]                         pres_a_ff, pres_b_ff;
   logic [31:0]                         pres_c_ff;
   bsc_pkg::calib_type                  calib;
   logic [bsc_pkg::PIPE_DEPTH-1:0]      valid_in, valid_ff;
   logic                                accept;
   logic signed [bsc_pkg::TQ_W-1:0]     tq;
   logic signed [bsc_pkg::TEMP_W-1:0]   temp_comp;
   logic                                temp_sat;
   bsc_pkg::coef_type                   coef;
   logic signed [bsc_pkg::N_W-1:0]      pres_scaled;
   logic signed [bsc_pkg::PW_W-1:0]     pres_wide;
   logic signed [bsc_pkg::TEMP_W-1:0]   tc_dly_ff [0:5];
   logic                                tsat_dly_ff [0:5];
   logic [bsc_pkg::PRES_W-1:0]          pres_in, pres_ff;
   logic                                psat_in;
   logic signed [bsc_pkg::TEMP_W-1:0]   temp_ff;
   logic                                sat_ff;

   // Calibration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         pres_a_ff     <= '0;
         pres_b_ff     <= '0;
         pres_c_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (bsc_pkg::csr_index_type'(csr_index))
            bsc_pkg::CSR_TEMP_CALIB:   temp_calib_ff <= csr_wdata[39:0];
            bsc_pkg::CSR_PRES_CALIB_A: pres_a_ff     <= csr_wdata;
            bsc_pkg::CSR_PRES_CALIB_B: pres_b_ff     <= csr_wdata;
            bsc_pkg::CSR_PRES_CALIB_C: pres_c_ff     <= csr_wdata[31:0];
         endcase
      end
   end

   // Little-endian calibration bytes to words.
   assign calib.t1  = temp_calib_ff[15:0];
   assign calib.t2  = temp_calib_ff[31:16];
   assign calib.t3  = temp_calib_ff[39:32];
   assign calib.p1  = pres_a_ff[15:0];
   assign calib.p2  = pres_a_ff[31:16];
   assign calib.p3  = pres_a_ff[39:32];
   assign calib.p4  = pres_a_ff[47:40];
   assign calib.p5  = pres_b_ff[15:0];
   assign calib.p6  = pres_b_ff[31:16];
   assign calib.p7  = pres_b_ff[39:32];
   assign calib.p8  = pres_b_ff[47:40];
   assign calib.p9  = pres_c_ff[15:0];
   assign calib.p10 = pres_c_ff[23:16];
   assign calib.p11 = pres_c_ff[31:24];

   // Stage valid bits travel beside the datapath.
   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign valid_in = {valid_ff[bsc_pkg::PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   bsc_temp u_temp (
      .clock      (clock),
      .temp_count (req_temp_count),
      .calib      (calib),
      .tq         (tq),
      .temp_comp  (temp_comp),
      .temp_sat   (temp_sat)
   );

   bsc_coef u_coef (
      .clock       (clock),
      .press_count (req_press_count),
      .calib       (calib),
      .coef        (coef)
   );

   bsc_horner u_horner (
      .clock       (clock),
      .tq          (tq),
      .coef        (coef),
      .pres_scaled (pres_scaled)
   );

   // Temperature result waits for the pressure evaluation.
   always_ff @(posedge clock) begin
      tc_dly_ff[0]   <= temp_comp;
      tsat_dly_ff[0] <= temp_sat;
      for (int i = 1; i < 6; i++) begin
         tc_dly_ff[i]   <= tc_dly_ff[i-1];
         tsat_dly_ff[i] <= tsat_dly_ff[i-1];
      end
   end

   // Pressure rounding and clamp into the result registers.
   assign pres_wide = pres_scaled[bsc_pkg::N_W-1:79];

   always_comb begin
      priority if (pres_wide < 0) begin
         pres_in = '0;
         psat_in = 1'b1;
      end else if (pres_wide > $signed({18'd0, bsc_pkg::PRES_MAX})) begin
         pres_in = bsc_pkg::PRES_MAX;
         psat_in = 1'b1;
      end else begin
         pres_in = pres_wide[bsc_pkg::PRES_W-1:0];
         psat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pres_ff <= pres_in;
      temp_ff <= tc_dly_ff[5];
      sat_ff  <= psat_in | tsat_dly_ff[5];
   end

   assign rsp_valid     = valid_ff[bsc_pkg::PIPE_DEPTH-1];
   assign rsp_temp_comp = temp_ff;
   assign rsp_pres_comp = pres_ff;
   assign rsp_saturated = sat_ff;

`ifndef SYNTHESIS
   // Every accepted item produces a result after the full pipeline depth.
   a_item_delivered: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##10 rsp_valid)
      else $error("accepted item produced no result");

   // No result without an item accepted the pipeline depth earlier.
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 10))
      else $error("result without an accepted item");

   // A flagged result must show a value at one of its limits.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_pres_comp == '0 || rsp_pres_comp == bsc_pkg::PRES_MAX ||
         rsp_temp_comp == bsc_pkg::TEMP_MIN || rsp_temp_comp == bsc_pkg::TEMP_MAX)
      else $error("saturation flag set away from the limits");
`endif

endmodule

`default_nettype wire
